FILE: sv/mbed_pkg.sv
// Shared types and constants of the multi-button edge debouncer.
// Holds the per-button state entry, request action codes, result kinds and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbed_pkg;

	// Configuration port layout.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 17;
	localparam int SETUP_W     = 17;
	localparam int SETUP_REGS  = 4;
	localparam int MASK_W      = 4;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_IN_USE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SETUP0 = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SETUP1 = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SETUP2 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SETUP3 = 3'd4;

	// Request actions.
	localparam logic [1:0] ACT_EDGE   = 2'd0;
	localparam logic [1:0] ACT_TICK   = 2'd1;
	localparam logic [1:0] ACT_INIT   = 2'd2;
	localparam logic [1:0] ACT_RESYNC = 2'd3;

	// Result kinds.
	localparam logic KIND_EVENT   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Debounce time limits in ms.
	localparam logic [7:0] DEBOUNCE_MIN_MS = 8'd1;
	localparam logic [7:0] DEBOUNCE_MAX_MS = 8'd200;

	// State kept for one button in the state memory.
	typedef struct packed {
		logic        stable;
		logic        raw;
		logic [31:0] start_ms;
		logic [7:0]  press;
		logic        boot;
	} entry_t;

endpackage

`default_nettype wire

FILE: sv/multi_button_edge_debouncer.sv
// Top level of the multi-button edge debouncer: configuration registers, state memory and sequencer.
// Depends on mbed_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Debounces up to NUM_BUTTONS buttons from timestamped pin edges. Per-button state lives in a
// small synchronous memory with a registered read; each button that a request reaches gets a read,
// an evaluate-and-write-back and at most one result, and a tick ends with a summary. An edge,
// init or resync request goes through accept, memory read and evaluate. An edge that matches no
// button in use, or an init or resync of a button beyond NUM_BUTTONS, is taken with no read and
// gives no result. A tick reads and evaluates each button in use in turn, then loads the
// summary. A full output register that is not being drained holds the evaluate step of a
// result and the summary load.
// Results leave through one output register. The block accepts no request while one is in work.
// The memory needs no clearing pass: a valid bit per entry makes an unwritten entry read as zero.
module multi_button_edge_debouncer #(
	parameter int NUM_BUTTONS = 4,
	parameter int DEFAULT_DEBOUNCE_MS = 20
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Configuration write port.
	input  wire                                 cfg_write,
	input  wire  [mbed_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire  [mbed_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Request channel.
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [1:0]                          action,
	input  wire  [1:0]                          button_index,
	input  wire  [7:0]                          pin,
	input  wire                                 level,
	input  wire  [31:0]                         stamp_ms,
	// Result channel.
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic                                kind,
	output logic [1:0]                          event_button,
	output logic                                went_down,
	output logic [31:0]                         event_time_ms,
	output logic [31:0]                         event_seq,
	output logic [7:0]                          press_number,
	output logic [7:0]                          next_wait_ms,
	output logic                                wait_pending,
	output logic [mbed_pkg::MASK_W-1:0]         down_mask,
	output logic [mbed_pkg::MASK_W-1:0]         boot_mask,
	output logic                                last
);

	localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int CW = $clog2(NUM_BUTTONS + 1);
	localparam logic [7:0] DEF_DEB = 8'(DEFAULT_DEBOUNCE_MS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;
	localparam logic [1:0] ST_SUM  = 2'd3;

	// Configuration registers.
	logic [2:0]                     in_use_q;
	logic [mbed_pkg::SETUP_W-1:0]   setup_q [mbed_pkg::SETUP_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int i = 0; i < mbed_pkg::SETUP_REGS; i++) begin
				setup_q[i] <= '0;
			end
		end else if (cfg_write) begin
			case (cfg_index)
				mbed_pkg::REG_IN_USE: in_use_q   <= cfg_data[2:0];
				mbed_pkg::REG_SETUP0: setup_q[0] <= cfg_data;
				mbed_pkg::REG_SETUP1: setup_q[1] <= cfg_data;
				mbed_pkg::REG_SETUP2: setup_q[2] <= cfg_data;
				mbed_pkg::REG_SETUP3: setup_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Number of buttons scanned, and which of the reported mask bits are in use.
	logic [CW-1:0]               n_use;
	logic [mbed_pkg::MASK_W-1:0] use_mask;

	always_comb begin
		n_use = (32'(in_use_q) > NUM_BUTTONS) ? CW'(NUM_BUTTONS) : CW'(in_use_q);
		for (int i = 0; i < mbed_pkg::MASK_W; i++) begin
			use_mask[i] = (i < 32'(n_use));
		end
	end

	// First button in use whose pin matches the incoming edge.
	logic          match_hit;
	logic [CW-1:0] match_idx;

	always_comb begin
		logic [7:0] bpin;
		match_hit = 1'b0;
		match_idx = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			bpin = (i < mbed_pkg::SETUP_REGS) ? setup_q[i[1:0]][7:0] : 8'd0;
			if (i < 32'(n_use) && bpin == pin) begin
				match_hit = 1'b1;
				match_idx = CW'(i);
			end
		end
	end

	// Sequencer registers.
	logic [1:0]              state_q;
	logic [1:0]              act_q;
	logic                    lvl_q;
	logic [31:0]             ts_q;
	logic [CW-1:0]           scan_q;
	logic                    pend_q;
	logic [7:0]              best_q;
	logic [31:0]             seq_q;
	logic [mbed_pkg::MASK_W-1:0] stab_q;
	logic [mbed_pkg::MASK_W-1:0] boot_q;

	// State memory with valid bits and a registered read.
	mbed_pkg::entry_t   mem [NUM_BUTTONS];
	mbed_pkg::entry_t   rd_q;
	logic [NUM_BUTTONS-1:0] vld_q;
	logic               rd_vld_q;
	logic [AW-1:0]      addr;
	logic               rd_en;
	logic               wr_en;
	mbed_pkg::entry_t   nxt;

	assign addr  = scan_q[AW-1:0];
	assign rd_en = (state_q == ST_READ);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= nxt;
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[addr];
			end
		end
	end

	// Setup of the button being worked on.
	logic [mbed_pkg::SETUP_W-1:0] cur_setup;
	logic [7:0]                   deb_raw;
	logic [7:0]                   deb;
	logic                         new_down;
	mbed_pkg::entry_t             cur;

	always_comb begin
		cur_setup = (32'(scan_q) < mbed_pkg::SETUP_REGS) ? setup_q[2'(scan_q)] : '0;
		deb_raw   = cur_setup[16:9];
		if (deb_raw < mbed_pkg::DEBOUNCE_MIN_MS) begin
			deb = DEF_DEB;
		end else if (deb_raw > mbed_pkg::DEBOUNCE_MAX_MS) begin
			deb = mbed_pkg::DEBOUNCE_MAX_MS;
		end else begin
			deb = deb_raw;
		end
		new_down = (lvl_q == cur_setup[8]);
		cur      = rd_vld_q ? rd_q : '0;
	end

	// Evaluate one button: decide the commit and the written-back entry.
	logic [31:0] elapsed;
	logic        settled;
	logic        differs;
	logic [7:0]  remain;
	logic        wr;
	logic        emit_evt;
	logic        evt_last;

	always_comb begin
		elapsed  = ts_q - cur.start_ms;
		settled  = (elapsed >= {24'd0, deb});
		differs  = (cur.raw != cur.stable);
		remain   = deb - elapsed[7:0];
		nxt      = cur;
		wr       = 1'b0;
		emit_evt = 1'b0;
		evt_last = 1'b0;
		case (act_q)
			mbed_pkg::ACT_EDGE: begin
				if (new_down != cur.raw) begin
					wr = 1'b1;
					if (differs && settled) begin
						nxt.stable = cur.raw;
						nxt.press  = cur.press + {7'd0, cur.raw};
						emit_evt   = 1'b1;
						evt_last   = 1'b1;
					end
					nxt.raw      = new_down;
					nxt.start_ms = ts_q;
				end
			end
			mbed_pkg::ACT_TICK: begin
				if (differs && settled) begin
					wr         = 1'b1;
					nxt.stable = cur.raw;
					nxt.press  = cur.press + {7'd0, cur.raw};
					emit_evt   = 1'b1;
				end
			end
			mbed_pkg::ACT_INIT: begin
				wr           = 1'b1;
				nxt.stable   = new_down;
				nxt.raw      = new_down;
				nxt.start_ms = ts_q;
				nxt.press    = 8'd0;
				nxt.boot     = new_down;
			end
			mbed_pkg::ACT_RESYNC: begin
				wr           = 1'b1;
				nxt.stable   = new_down;
				nxt.raw      = new_down;
				nxt.start_ms = ts_q;
			end
			default: ;
		endcase
	end

	// Hold the evaluate step while a result cannot be loaded.
	logic out_valid_q;
	logic out_free;
	logic go;

	assign out_free = !out_valid_q || out_ready;
	assign go       = (state_q == ST_EVAL) && (!emit_evt || out_free);
	assign wr_en    = go && wr;

	// Mirror of stable and boot flags for the mask outputs, with this step's write applied.
	logic [mbed_pkg::MASK_W-1:0] stab_nx;
	logic [mbed_pkg::MASK_W-1:0] boot_nx;

	always_comb begin
		stab_nx = stab_q;
		boot_nx = boot_q;
		if (wr && 32'(scan_q) < mbed_pkg::MASK_W) begin
			stab_nx[2'(scan_q)] = nxt.stable;
			boot_nx[2'(scan_q)] = nxt.boot;
		end
	end

	// Sequencer.
	logic in_acc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q   <= mbed_pkg::ACT_EDGE;
			lvl_q   <= 1'b0;
			ts_q    <= '0;
			scan_q  <= '0;
			pend_q  <= 1'b0;
			best_q  <= '0;
			seq_q   <= '0;
			stab_q  <= '0;
			boot_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						act_q <= action;
						lvl_q <= level;
						ts_q  <= stamp_ms;
						case (action)
							mbed_pkg::ACT_EDGE: begin
								if (match_hit) begin
									scan_q  <= match_idx;
									state_q <= ST_READ;
								end
							end
							mbed_pkg::ACT_TICK: begin
								pend_q  <= 1'b0;
								best_q  <= '0;
								scan_q  <= '0;
								state_q <= (n_use == '0) ? ST_SUM : ST_READ;
							end
							default: begin
								if (32'(button_index) < NUM_BUTTONS) begin
									scan_q  <= CW'(button_index);
									state_q <= ST_READ;
								end
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (go) begin
						stab_q <= stab_nx;
						boot_q <= boot_nx;
						if (emit_evt) begin
							seq_q <= seq_q + 32'd1;
						end
						if (act_q == mbed_pkg::ACT_TICK) begin
							// Track the shortest wait of buttons still bouncing.
							if (differs && !settled && (!pend_q || remain < best_q)) begin
								pend_q <= 1'b1;
								best_q <= remain;
							end
							if (32'(scan_q) + 1 < 32'(n_use)) begin
								scan_q  <= scan_q + CW'(1);
								state_q <= ST_READ;
							end else begin
								state_q <= ST_SUM;
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SUM: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: loaded by an event or a summary, emptied when taken.
	logic load_evt;
	logic load_sum;

	assign load_evt = go && emit_evt;
	assign load_sum = (state_q == ST_SUM) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_evt || load_sum) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	logic                        kind_q;
	logic [1:0]                  button_q;
	logic                        down_q;
	logic [31:0]                 time_q;
	logic [31:0]                 evseq_q;
	logic [7:0]                  press_q;
	logic [7:0]                  wait_q;
	logic                        waitp_q;
	logic [mbed_pkg::MASK_W-1:0] dmask_q;
	logic [mbed_pkg::MASK_W-1:0] bmask_q;
	logic                        last_q;

	always_ff @(posedge clk) begin
		if (load_evt) begin
			kind_q   <= mbed_pkg::KIND_EVENT;
			button_q <= 2'(scan_q);
			down_q   <= nxt.stable;
			time_q   <= cur.start_ms;
			evseq_q  <= seq_q;
			press_q  <= nxt.press;
			wait_q   <= '0;
			waitp_q  <= 1'b0;
			dmask_q  <= stab_nx & use_mask;
			bmask_q  <= boot_nx & use_mask;
			last_q   <= evt_last;
		end else if (load_sum) begin
			kind_q   <= mbed_pkg::KIND_SUMMARY;
			button_q <= '0;
			down_q   <= 1'b0;
			time_q   <= '0;
			evseq_q  <= '0;
			press_q  <= '0;
			wait_q   <= pend_q ? best_q : 8'd0;
			waitp_q  <= pend_q;
			dmask_q  <= stab_q & use_mask;
			bmask_q  <= boot_q & use_mask;
			last_q   <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign event_button  = button_q;
	assign went_down     = down_q;
	assign event_time_ms = time_q;
	assign event_seq     = evseq_q;
	assign press_number  = press_q;
	assign next_wait_ms  = wait_q;
	assign wait_pending  = waitp_q;
	assign down_mask     = dmask_q;
	assign boot_mask     = bmask_q;
	assign last          = last_q;

endmodule

`default_nettype wire

FILE: sv/mbed_checker.sv
// Port-level checker of the multi-button edge debouncer and the bind that attaches it.
// Depends on mbed_pkg and on the ports of multi_button_edge_debouncer.
`timescale 1ns / 1ps
`default_nettype none

module mbed_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         in_ready,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire                         kind,
	input wire [1:0]                   event_button,
	input wire                         went_down,
	input wire [31:0]                  event_time_ms,
	input wire [31:0]                  event_seq,
	input wire [7:0]                   press_number,
	input wire [7:0]                   next_wait_ms,
	input wire                         wait_pending,
	input wire [mbed_pkg::MASK_W-1:0]  down_mask,
	input wire [mbed_pkg::MASK_W-1:0]  boot_mask,
	input wire                         last
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_seq) && $stable(kind)
			&& $stable(last) && $stable(down_mask) && $stable(next_wait_ms))
		else $error("result changed while stalled");

	// A summary always closes the results of its request.
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == mbed_pkg::KIND_SUMMARY |-> last)
		else $error("summary without last");

	// Events carry no wait report, and a summary without a pending wait reports zero.
	a_wait_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == mbed_pkg::KIND_EVENT || !wait_pending) |-> next_wait_ms == 8'd0)
		else $error("wait reported where none is pending");

	// While a tick still has results to give, no new request is taken.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("request taken in the middle of a tick");

endmodule

bind multi_button_edge_debouncer mbed_checker u_mbed_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.event_button (event_button),
	.went_down    (went_down),
	.event_time_ms(event_time_ms),
	.event_seq    (event_seq),
	.press_number (press_number),
	.next_wait_ms (next_wait_ms),
	.wait_pending (wait_pending),
	.down_mask    (down_mask),
	.boot_mask    (boot_mask),
	.last         (last)
);

`default_nettype wire
